// File: hdl/bsc_pkg.sv
// bsc_pkg: shared types and constants for the barometric compensation pipeline
// depends on nothing; used by every module under hdl

package bsc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_TEMP_COEF  = 2'd0;
	localparam logic [1:0] REG_PRES_LOW   = 2'd1;
	localparam logic [1:0] REG_PRES_HIGH  = 2'd2;
	localparam logic [1:0] REG_PRES_NINE  = 2'd3;

	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 64;
	localparam int QuoBits       = 64;

	// stage counts of each section
	localparam int TempStages  = 5;
	localparam int CoefStages  = 5;
	localparam int DivStages   = QuoBits + 2;
	localparam int FinalStages = 3;
	localparam int Latency     = TempStages + CoefStages + DivStages + FinalStages;

	// results that ride alongside the pressure datapath
	typedef struct packed {
		logic signed [31:0] temp_centi;
		logic signed [31:0] fine_temp;
		logic               invalid;
	} side_t;

endpackage

// File: hdl/bsc_temp.sv
// bsc_temp: temperature compensation, five pipeline stages (32-bit wrapping)
// depends on bsc_pkg

module bsc_temp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	input  logic [47:0]        temp_coef,
	output logic               valid_s5,
	output bsc_pkg::side_t     side_s5,
	output logic signed [32:0] v1_s5,
	output logic [19:0]        adc_p_s5
);

	logic [15:0]        t1;
	logic signed [15:0] t2;
	logic signed [15:0] t3;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [17:0] a_s1;
	logic signed [16:0] d_s1;
	logic signed [33:0] pa_s2;
	logic [31:0]        sq_s2;
	logic signed [31:0] ta_s3;
	logic signed [35:0] pb_s3;
	logic signed [31:0] tf_s4;
	logic [19:0] adc_p_s1, adc_p_s2, adc_p_s3, adc_p_s4;

	logic signed [19:0] sq12;
	logic signed [31:0] tc_pre;

	assign t1 = temp_coef[15:0];
	assign t2 = $signed(temp_coef[31:16]);
	assign t3 = $signed(temp_coef[47:32]);

	assign sq12   = 20'($signed(sq_s2) >>> 12);
	assign tc_pre = tf_s4 * 32'sd5 + 32'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		a_s1     <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
		d_s1     <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
		adc_p_s1 <= raw_pressure;

		pa_s2    <= a_s1 * t2;
		sq_s2    <= 32'(d_s1 * d_s1);
		adc_p_s2 <= adc_p_s1;

		ta_s3    <= $signed(pa_s2[31:0]) >>> 11;
		pb_s3    <= sq12 * t3;
		adc_p_s3 <= adc_p_s2;

		tf_s4    <= ta_s3 + ($signed(pb_s3[31:0]) >>> 14);
		adc_p_s4 <= adc_p_s3;

		side_s5.temp_centi <= tc_pre >>> 8;
		side_s5.fine_temp  <= tf_s4;
		side_s5.invalid    <= 1'b0;
		v1_s5    <= $signed({tf_s4[31], tf_s4}) - 33'sd128000;
		adc_p_s5 <= adc_p_s4;
	end

endmodule

// File: hdl/bsc_pcoef.sv
// bsc_pcoef: pressure divisor and numerator, five pipeline stages (64-bit wrapping)
// depends on bsc_pkg

module bsc_pcoef (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s5,
	input  bsc_pkg::side_t     side_s5,
	input  logic signed [32:0] v1_s5,
	input  logic [19:0]        adc_p_s5,
	input  logic [63:0]        pres_low,
	input  logic [63:0]        pres_high,
	output logic               valid_s10,
	output bsc_pkg::side_t     side_s10,
	output logic signed [63:0] num_s10,
	output logic signed [63:0] den_s10
);

	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6;

	logic valid_s6, valid_s7, valid_s8, valid_s9;
	bsc_pkg::side_t side_s6, side_s7, side_s8, side_s9;
	logic [19:0] adc_p_s6, adc_p_s7, adc_p_s8;

	logic signed [63:0] vsq_s6;
	logic signed [48:0] m5_s6, m2_s6, m2_s7;
	logic signed [63:0] v2a_s7, m3_s7, part_s7;
	logic signed [63:0] v2_s8, v1b_s8;
	logic signed [63:0] y_s9, diff_s9;
	logic [20:0]        pr21;

	assign p1 = pres_low[15:0];
	assign p2 = $signed(pres_low[31:16]);
	assign p3 = $signed(pres_low[47:32]);
	assign p4 = $signed(pres_low[63:48]);
	assign p5 = $signed(pres_high[15:0]);
	assign p6 = $signed(pres_high[31:16]);

	assign pr21 = 21'd1048576 - {1'b0, adc_p_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		vsq_s6   <= 64'(v1_s5 * v1_s5);
		m5_s6    <= v1_s5 * p5;
		m2_s6    <= v1_s5 * p2;
		side_s6  <= side_s5;
		adc_p_s6 <= adc_p_s5;

		v2a_s7   <= 64'(vsq_s6 * p6);
		m3_s7    <= 64'(vsq_s6 * p3);
		part_s7  <= (64'(m5_s6) <<< 17) + (64'(p4) <<< 35);
		m2_s7    <= m2_s6;
		side_s7  <= side_s6;
		adc_p_s7 <= adc_p_s6;

		v2_s8    <= v2a_s7 + part_s7;
		v1b_s8   <= (m3_s7 >>> 8) + (64'(m2_s7) <<< 12);
		side_s8  <= side_s7;
		adc_p_s8 <= adc_p_s7;

		y_s9     <= 64'((v1b_s8 + 64'sh0000_8000_0000_0000) * $signed({1'b0, p1}));
		diff_s9  <= ($signed({43'd0, pr21}) <<< 31) - v2_s8;
		side_s9  <= side_s8;

		den_s10  <= y_s9 >>> 33;
		num_s10  <= 64'(diff_s9 * 64'sd3125);
		side_s10 <= side_s9;
	end

endmodule

// File: hdl/bsc_div.sv
// bsc_div: pipelined signed 64-bit division truncating toward zero
// one quotient bit per stage; depends on bsc_pkg

module bsc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  bsc_pkg::side_t     side_in,
	input  logic signed [63:0] num_in,
	input  logic signed [63:0] den_in,
	output logic               valid_out,
	output bsc_pkg::side_t     side_out,
	output logic signed [63:0] quo_out
);

	localparam int N = bsc_pkg::QuoBits;

	logic           vld_s  [0:N];
	logic [63:0]    rem_s  [0:N];
	logic [63:0]    nq_s   [0:N];
	logic [63:0]    dvs_s  [0:N];
	logic           neg_s  [0:N];
	bsc_pkg::side_t side_s [0:N];

	// magnitude stage, zero divisor flagged here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		nq_s[0]   <= num_in[63] ? 64'(-num_in) : 64'(num_in);
		dvs_s[0]  <= den_in[63] ? 64'(-den_in) : 64'(den_in);
		neg_s[0]  <= num_in[63] ^ den_in[63];
		side_s[0] <= '{temp_centi: side_in.temp_centi, fine_temp: side_in.fine_temp,
			invalid: (den_in == 64'sd0)};
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [64:0] trial;
		logic        fits;

		assign trial = {rem_s[k-1], nq_s[k-1][63]};
		assign fits  = trial >= {1'b0, dvs_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= fits ? 64'(trial - {1'b0, dvs_s[k-1]}) : trial[63:0];
			nq_s[k]   <= {nq_s[k-1][62:0], fits};
			dvs_s[k]  <= dvs_s[k-1];
			neg_s[k]  <= neg_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	// sign restore
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		quo_out  <= neg_s[N] ? $signed(64'(-nq_s[N])) : $signed(nq_s[N]);
		side_out <= side_s[N];
	end

endmodule

// File: hdl/bsc_pfin.sv
// bsc_pfin: second-order pressure correction, three pipeline stages
// depends on bsc_pkg

module bsc_pfin (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  bsc_pkg::side_t     side_in,
	input  logic signed [63:0] quo_in,
	input  logic [63:0]        pres_high,
	input  logic [15:0]        pres_nine,
	output logic               valid_out,
	output logic signed [31:0] temperature_centi,
	output logic signed [31:0] fine_temperature,
	output logic [31:0]        pressure_q24_8,
	output logic               pressure_invalid
);

	logic signed [15:0] p7, p8, p9;
	logic signed [63:0] ps;
	logic [63:0]        sqv;
	logic signed [63:0] e_val, r_val;

	logic valid_a, valid_b;
	bsc_pkg::side_t side_a, side_b;
	logic [63:0]        ll_a;
	logic [31:0]        lh_a;
	logic signed [63:0] fp_a, q_a;
	logic signed [63:0] ep_b, f_b, q_b;

	assign p7 = $signed(pres_high[47:32]);
	assign p8 = $signed(pres_high[63:48]);
	assign p9 = $signed(pres_nine);

	assign ps    = quo_in >>> 13;
	// square of ps kept modulo 2^64 from 32-bit halves
	assign sqv   = ll_a + {lh_a[30:0], 33'd0};
	assign e_val = ep_b >>> 25;
	assign r_val = ((q_b + e_val + f_b) >>> 8) + (64'(p7) <<< 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_a   <= 1'b0;
			valid_b   <= 1'b0;
			valid_out <= 1'b0;
		end else begin
			valid_a   <= valid_in;
			valid_b   <= valid_a;
			valid_out <= valid_b;
		end
	end

	always_ff @(posedge clk) begin
		ll_a   <= 64'(ps[31:0]) * 64'(ps[31:0]);
		lh_a   <= 32'(ps[63:32] * ps[31:0]);
		fp_a   <= 64'(quo_in * p8);
		q_a    <= quo_in;
		side_a <= side_in;

		ep_b   <= 64'($signed(sqv) * p9);
		f_b    <= fp_a >>> 19;
		q_b    <= q_a;
		side_b <= side_a;

		temperature_centi <= side_b.temp_centi;
		fine_temperature  <= side_b.fine_temp;
		pressure_invalid  <= side_b.invalid;
		pressure_q24_8    <= side_b.invalid ? 32'd0 : r_val[31:0];
	end

endmodule

// File: hdl/baro_sensor_compensation.sv
// baro_sensor_compensation: top level, configuration registers and pipeline
// depends on bsc_pkg, bsc_temp, bsc_pcoef, bsc_div, bsc_pfin

// usage
//  - a reading pair (raw_temperature, raw_pressure) is transferred at a rising
//    edge with start high and busy low; busy is held low, so a new pair may
//    be transferred in every cycle
//  - each transfer gives exactly one result: done is high for one cycle with
//    temperature_centi, fine_temperature, pressure_q24_8 and pressure_invalid
//  - the path from the start transfer to the done cycle runs through
//    5 temperature stages, 5 pressure coefficient stages, 66 divider stages
//    (magnitude, 64 restoring steps of one quotient bit each, sign restore)
//    and 3 correction stages; the 64-step divider sets the depth
//  - throughput is one result per cycle, results leave in transfer order
//  - the receiver cannot stall: done is a strobe and results are not held
//  - calibration is written through cfg_we / cfg_index / cfg_data; the user
//    must write it only while no reading is in flight (the block has no check);
//    register 0 uses the low 48 bits, register 3 the low 16 bits
//  - asynchronous reset clears all valid bits and the calibration registers;
//    nothing is in flight afterwards and no clearing pass is needed
//  - a zero divisor gives pressure_q24_8 of zero and pressure_invalid high

module baro_sensor_compensation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [19:0]                          raw_temperature,
	input  logic [19:0]                          raw_pressure,
	output logic                                 done,
	output logic signed [31:0]                   temperature_centi,
	output logic signed [31:0]                   fine_temperature,
	output logic [31:0]                          pressure_q24_8,
	output logic                                 pressure_invalid,
	input  logic                                 cfg_we,
	input  logic [bsc_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  logic [bsc_pkg::CfgDataWidth-1:0]     cfg_data
);

	// calibration registers
	logic [47:0] temp_coef_q;
	logic [63:0] pres_low_q;
	logic [63:0] pres_high_q;
	logic [15:0] pres_nine_q;

	// inter-section links
	logic               valid_s5, valid_s10, valid_div;
	bsc_pkg::side_t     side_s5, side_s10, side_div;
	logic signed [32:0] v1_s5;
	logic [19:0]        adc_p_s5;
	logic signed [63:0] num_s10, den_s10, quo_div;

	// the pipeline never refuses a transfer
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coef_q <= '0;
			pres_low_q  <= '0;
			pres_high_q <= '0;
			pres_nine_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bsc_pkg::REG_TEMP_COEF: temp_coef_q <= cfg_data[47:0];
				bsc_pkg::REG_PRES_LOW:  pres_low_q  <= cfg_data;
				bsc_pkg::REG_PRES_HIGH: pres_high_q <= cfg_data;
				bsc_pkg::REG_PRES_NINE: pres_nine_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// fine temperature and centi-degree result
	bsc_temp u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (start & ~busy),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.temp_coef       (temp_coef_q),
		.valid_s5        (valid_s5),
		.side_s5         (side_s5),
		.v1_s5           (v1_s5),
		.adc_p_s5        (adc_p_s5)
	);

	// divisor and numerator of the pressure quotient
	bsc_pcoef u_pcoef (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s5  (valid_s5),
		.side_s5   (side_s5),
		.v1_s5     (v1_s5),
		.adc_p_s5  (adc_p_s5),
		.pres_low  (pres_low_q),
		.pres_high (pres_high_q),
		.valid_s10 (valid_s10),
		.side_s10  (side_s10),
		.num_s10   (num_s10),
		.den_s10   (den_s10)
	);

	// signed quotient, one bit per stage
	bsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s10),
		.side_in   (side_s10),
		.num_in    (num_s10),
		.den_in    (den_s10),
		.valid_out (valid_div),
		.side_out  (side_div),
		.quo_out   (quo_div)
	);

	// second-order correction and output registers
	bsc_pfin u_pfin (
		.clk               (clk),
		.arst_n            (arst_n),
		.valid_in          (valid_div),
		.side_in           (side_div),
		.quo_in            (quo_div),
		.pres_high         (pres_high_q),
		.pres_nine         (pres_nine_q),
		.valid_out         (done),
		.temperature_centi (temperature_centi),
		.fine_temperature  (fine_temperature),
		.pressure_q24_8    (pressure_q24_8),
		.pressure_invalid  (pressure_invalid)
	);

endmodule

// File: hdl/bsc_checker.sv
// bsc_checker: port-level checks of the compensation block, bound to the top
// depends on bsc_pkg and baro_sensor_compensation

module bsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] pressure_q24_8,
	input logic        pressure_invalid
);

	// every transfer comes out after the full pipeline depth
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(bsc_pkg::Latency) done)
		else $error("transfer produced no result");

	// no result without a matching transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, bsc_pkg::Latency))
		else $error("result without transfer");

	// a zero divisor forces the pressure to zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pressure_invalid) |-> (pressure_q24_8 == 32'd0))
		else $error("invalid pressure not zero");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("transfer refused");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.pressure_q24_8   (pressure_q24_8),
	.pressure_invalid (pressure_invalid)
);
